FILE: hw/rtl/dgr_pkg.sv
package dgr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IDX_W      = 6;
  localparam int PEN_W      = 16;
  localparam int PROD_W     = 14;
  localparam int UPC_W      = 5;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PEN_W-1:0]  pen_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [UPC_W-1:0]  upc_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y        = 2'd3;

  // Character codes that draw.
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_2   = 8'h32;
  localparam logic [7:0] CH_3   = 8'h33;
  localparam logic [7:0] CH_4   = 8'h34;
  localparam logic [7:0] CH_5   = 8'h35;
  localparam logic [7:0] CH_6   = 8'h36;
  localparam logic [7:0] CH_7   = 8'h37;
  localparam logic [7:0] CH_8   = 8'h38;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // Program entry points in the control store.
  localparam upc_t ADDR_ZERO  = 5'd0;
  localparam upc_t ADDR_ONE   = 5'd4;
  localparam upc_t ADDR_TWO   = 5'd5;
  localparam upc_t ADDR_FOUR  = 5'd10;
  localparam upc_t ADDR_SIX   = 5'd14;
  localparam upc_t ADDR_SEVEN = 5'd21;
  localparam upc_t ADDR_DOT   = 5'd23;

  typedef enum logic [1:0] {X_GX, X_RX, X_RX_NOT5, X_RX_NOT2} xsel_t;
  typedef enum logic [2:0] {Y_ZERO, Y_T, Y_2T, Y_F, Y_2F, Y_3F, Y_4F, Y_SY} ysel_t;
  typedef enum logic [2:0] {H_T, H_F, H_FULL, H_4F, H_SZ} hsel_t;
  typedef enum logic [1:0] {W_FULL, W_BAR, W_HALF, W_SZ} wsel_t;
  typedef enum logic [1:0] {SK_NONE, SK_SIX, SK_NINE} skip_t;

  typedef struct packed {
    xsel_t xsel;
    ysel_t ysel;
    hsel_t hsel;
    wsel_t wsel;
    skip_t skip;
    logic  last;
  } cw_t;

  typedef struct packed {
    logic has_prog;
    upc_t addr;
  } entry_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic  accept;
    logic  prep;
    logic  load;
    logic  x_rx;
    ysel_t ysel;
    hsel_t hsel;
    wsel_t wsel;
    logic  last;
  } ctl_t;

  function automatic cw_t mk(input xsel_t x, input ysel_t y, input hsel_t h,
                             input wsel_t w, input skip_t s, input logic l);
    cw_t cw;
    cw.xsel = x;
    cw.ysel = y;
    cw.hsel = h;
    cw.wsel = w;
    cw.skip = s;
    cw.last = l;
    return cw;
  endfunction

  function automatic cw_t rom_word(input upc_t a);
    cw_t cw;
    unique case (a)
      // Zero: top bar, two side bars, bottom bar, in thirds.
      ADDR_ZERO:          cw = mk(X_GX, Y_ZERO, H_T, W_FULL, SK_NONE, 1'b0);
      ADDR_ZERO + 5'd1:   cw = mk(X_GX, Y_T,    H_T, W_BAR,  SK_NONE, 1'b0);
      ADDR_ZERO + 5'd2:   cw = mk(X_RX, Y_T,    H_T, W_BAR,  SK_NONE, 1'b0);
      ADDR_ZERO + 5'd3:   cw = mk(X_GX, Y_2T,   H_T, W_FULL, SK_NONE, 1'b1);
      ADDR_ONE:           cw = mk(X_GX, Y_ZERO, H_FULL, W_HALF, SK_NONE, 1'b1);
      // Two, three and five share one program; the side picks the bar.
      ADDR_TWO:           cw = mk(X_GX,      Y_ZERO, H_F, W_FULL, SK_NONE, 1'b0);
      ADDR_TWO + 5'd1:    cw = mk(X_RX_NOT5, Y_F,    H_F, W_BAR,  SK_NONE, 1'b0);
      ADDR_TWO + 5'd2:    cw = mk(X_GX,      Y_2F,   H_F, W_FULL, SK_NONE, 1'b0);
      ADDR_TWO + 5'd3:    cw = mk(X_RX_NOT2, Y_3F,   H_F, W_BAR,  SK_NONE, 1'b0);
      ADDR_TWO + 5'd4:    cw = mk(X_GX,      Y_4F,   H_F, W_FULL, SK_NONE, 1'b1);
      ADDR_FOUR:          cw = mk(X_GX, Y_ZERO, H_T, W_BAR,  SK_NONE, 1'b0);
      ADDR_FOUR + 5'd1:   cw = mk(X_RX, Y_ZERO, H_T, W_BAR,  SK_NONE, 1'b0);
      ADDR_FOUR + 5'd2:   cw = mk(X_GX, Y_T,    H_T, W_FULL, SK_NONE, 1'b0);
      ADDR_FOUR + 5'd3:   cw = mk(X_RX, Y_2T,   H_T, W_BAR,  SK_NONE, 1'b1);
      // Eight in full; six jumps over the upper right bar, nine over the
      // lower left one.
      ADDR_SIX:           cw = mk(X_GX, Y_ZERO, H_F, W_FULL, SK_NONE, 1'b0);
      ADDR_SIX + 5'd1:    cw = mk(X_GX, Y_F,    H_F, W_BAR,  SK_NONE, 1'b0);
      ADDR_SIX + 5'd2:    cw = mk(X_RX, Y_F,    H_F, W_BAR,  SK_SIX,  1'b0);
      ADDR_SIX + 5'd3:    cw = mk(X_GX, Y_2F,   H_F, W_FULL, SK_NONE, 1'b0);
      ADDR_SIX + 5'd4:    cw = mk(X_GX, Y_3F,   H_F, W_BAR,  SK_NINE, 1'b0);
      ADDR_SIX + 5'd5:    cw = mk(X_RX, Y_3F,   H_F, W_BAR,  SK_NONE, 1'b0);
      ADDR_SIX + 5'd6:    cw = mk(X_GX, Y_4F,   H_F, W_FULL, SK_NONE, 1'b1);
      ADDR_SEVEN:         cw = mk(X_GX, Y_ZERO, H_F,  W_FULL, SK_NONE, 1'b0);
      ADDR_SEVEN + 5'd1:  cw = mk(X_RX, Y_F,    H_4F, W_BAR,  SK_NONE, 1'b1);
      ADDR_DOT:           cw = mk(X_GX, Y_SY,   H_SZ, W_SZ,   SK_NONE, 1'b1);
      default:            cw = mk(X_GX, Y_ZERO, H_T,  W_FULL, SK_NONE, 1'b1);
    endcase
    return cw;
  endfunction

  function automatic entry_t entry_of(input logic [7:0] c);
    entry_t e;
    e.has_prog = 1'b1;
    unique case (c)
      CH_0:                 e.addr = ADDR_ZERO;
      CH_1:                 e.addr = ADDR_ONE;
      CH_2, CH_3, CH_5:     e.addr = ADDR_TWO;
      CH_4:                 e.addr = ADDR_FOUR;
      CH_6, CH_8, CH_9:     e.addr = ADDR_SIX;
      CH_7:                 e.addr = ADDR_SEVEN;
      CH_DOT:               e.addr = ADDR_DOT;
      default: begin
        e.has_prog = 1'b0;
        e.addr     = ADDR_ZERO;
      end
    endcase
    return e;
  endfunction

  // Division by constants through reciprocal multiplication, exact over
  // the argument ranges used here.
  function automatic logic [7:0] div3(input logic [8:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd171;
    return p[16:9];
  endfunction

  function automatic logic [7:0] div5(input logic [7:0] x);
    logic [17:0] p;
    p = 18'(x) * 18'd205;
    return p[17:10];
  endfunction

  function automatic logic [7:0] div6(input logic [10:0] x);
    logic [21:0] p;
    p = 22'(x) * 22'd1366;
    return p[20:13];
  endfunction

endpackage

FILE: hw/rtl/dgr_char_if.sv
interface dgr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       restart;

  modport source (output valid, output char_code, output restart, input ready);
  modport sink   (input valid, input char_code, input restart, output ready);
endinterface

FILE: hw/rtl/dgr_rect_if.sv
interface dgr_rect_if;
  logic        valid;
  logic        ready;
  logic [15:0] rect_x;
  logic [12:0] rect_y;
  logic [7:0]  rect_height;
  logic [7:0]  rect_width;
  logic        last;

  modport source (output valid, output rect_x, output rect_y, output rect_height,
                  output rect_width, output last, input ready);
  modport sink   (input valid, input rect_x, input rect_y, input rect_height,
                  input rect_width, input last, output ready);
endinterface

FILE: hw/rtl/digit_glyph_rectangle_generator.sv
// Channel    Direction  Beat payload
// char_in    in         char_code[7:0], restart
// rect_out   out        rect_x[15:0], rect_y[12:0], rect_height[7:0],
//                       rect_width[7:0], last
//
// A drawing character first passes the setup steps (offset multiply, then the
// left and right edge adds) and then gives one rectangle per cycle from the
// control store while the output is free; a bar that six or nine jumps over
// takes a step of its own. Any other character leaves the sequencer idle.
// Reset is synchronous and restores the register defaults, the pen and index.
// A stalled output holds the sequencer on its current step; char_in.ready is
// high whenever no character is being drawn.
module digit_glyph_rectangle_generator #(
  parameter int MAX_CHARS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  dgr_char_if.sink                          char_in,
  dgr_rect_if.source                        rect_out,
  input  logic                              wr_en,
  input  logic [dgr_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [dgr_pkg::CFG_DATA_W-1:0]    wr_data
);

  dgr_pkg::ctl_t ctl;
  logic          out_free;

  dgr_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (char_in.valid),
    .char_code (char_in.char_code),
    .out_free  (out_free),
    .ready     (char_in.ready),
    .ctl       (ctl)
  );

  dgr_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .restart  (char_in.restart),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .out_free (out_free),
    .rect_out (rect_out)
  );

endmodule

FILE: hw/rtl/dgr_sequencer.sv
module dgr_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        char_code,
  input  logic              out_free,
  output logic              ready,
  output dgr_pkg::ctl_t     ctl
);

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_RUN} state_t;

  state_t           state;
  dgr_pkg::upc_t    upc;
  logic             is_two;
  logic             is_five;
  logic             is_six;
  logic             is_nine;
  dgr_pkg::cw_t     cw;
  dgr_pkg::entry_t  entry;
  logic             accept;
  logic             skip;
  logic             x_rx;

  assign ready  = (state == S_IDLE);
  assign accept = in_valid & ready;
  assign entry  = dgr_pkg::entry_of(char_code);
  assign cw     = dgr_pkg::rom_word(upc);

  // A conditional step is jumped over for the digits that lack that bar.
  assign skip = ((cw.skip == dgr_pkg::SK_SIX) && is_six) ||
                ((cw.skip == dgr_pkg::SK_NINE) && is_nine);

  always_comb begin
    unique case (cw.xsel)
      dgr_pkg::X_GX:      x_rx = 1'b0;
      dgr_pkg::X_RX:      x_rx = 1'b1;
      dgr_pkg::X_RX_NOT5: x_rx = ~is_five;
      dgr_pkg::X_RX_NOT2: x_rx = ~is_two;
      default:            x_rx = 1'b0;
    endcase
  end

  always_comb begin
    ctl.accept = accept;
    ctl.prep   = (state == S_PREP);
    ctl.load   = (state == S_RUN) && !skip && out_free;
    ctl.x_rx   = x_rx;
    ctl.ysel   = cw.ysel;
    ctl.hsel   = cw.hsel;
    ctl.wsel   = cw.wsel;
    ctl.last   = cw.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      upc   <= dgr_pkg::ADDR_ZERO;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            upc     <= entry.addr;
            is_two  <= (char_code == dgr_pkg::CH_2);
            is_five <= (char_code == dgr_pkg::CH_5);
            is_six  <= (char_code == dgr_pkg::CH_6);
            is_nine <= (char_code == dgr_pkg::CH_9);
            state   <= entry.has_prog ? S_PREP : S_IDLE;
          end
        end
        S_PREP: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (skip) begin
            upc <= upc + 1'b1;
          end else if (out_free) begin
            if (cw.last) begin
              state <= S_IDLE;
            end else begin
              upc <= upc + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/dgr_datapath.sv
module dgr_datapath #(
  parameter int MAX_CHARS = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dgr_pkg::ctl_t                     ctl,
  input  logic                              restart,
  input  logic                              wr_en,
  input  logic [dgr_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [dgr_pkg::CFG_DATA_W-1:0]    wr_data,
  output logic                              out_free,
  dgr_rect_if.source                        rect_out
);

  localparam int IDX_MAX = (1 << dgr_pkg::IDX_W) - 1;
  localparam int BOUND_I = (MAX_CHARS > IDX_MAX) ? IDX_MAX : MAX_CHARS;
  localparam dgr_pkg::idx_t BOUND = dgr_pkg::idx_t'(BOUND_I);

  logic [7:0]     glyph_height;
  logic [7:0]     glyph_width;
  logic [11:0]    start_x;
  logic [11:0]    top_y;

  dgr_pkg::pen_t  pen_x;
  dgr_pkg::idx_t  char_index;

  // Values derived from the configuration, refreshed every cycle.
  logic [8:0]     w3x2;
  logic [7:0]     bw;
  logic [7:0]     half;
  logic [7:0]     t;
  logic [7:0]     t2;
  logic [7:0]     f;
  logic [7:0]     f2;
  logic [7:0]     f3;
  logic [7:0]     f4;
  logic [7:0]     sy;
  logic [7:0]     sz;

  dgr_pkg::pen_t  item_pen;
  dgr_pkg::prod_t prod;
  dgr_pkg::pen_t  gx;
  dgr_pkg::pen_t  rx;

  dgr_pkg::pen_t  pen_base;
  dgr_pkg::idx_t  idx_base;
  logic [7:0]     f_w;
  logic [7:0]     t_w;
  logic [7:0]     yoff;
  logic [7:0]     hval;
  logic [7:0]     wval;

  logic           out_valid;
  logic [15:0]    out_x;
  logic [12:0]    out_y;
  logic [7:0]     out_h;
  logic [7:0]     out_w;
  logic           out_last;

  assign pen_base = restart ? dgr_pkg::pen_t'(start_x) : pen_x;
  assign idx_base = restart ? '0 : char_index;
  assign t_w      = dgr_pkg::div3({1'b0, glyph_height});
  assign f_w      = dgr_pkg::div5(glyph_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_height <= 8'd15;
      glyph_width  <= 8'd9;
      start_x      <= 12'd0;
      top_y        <= 12'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        dgr_pkg::REG_GLYPH_HEIGHT: glyph_height <= wr_data[7:0];
        dgr_pkg::REG_GLYPH_WIDTH:  glyph_width  <= wr_data[7:0];
        dgr_pkg::REG_START_X:      start_x      <= wr_data;
        dgr_pkg::REG_TOP_Y:        top_y        <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    w3x2 <= {dgr_pkg::div3({1'b0, glyph_width}), 1'b0};
    bw   <= dgr_pkg::div3(9'(glyph_width) + 9'd2);
    half <= {1'b0, glyph_width[7:1]};
    t    <= t_w;
    t2   <= {t_w[6:0], 1'b0};
    f    <= f_w;
    f2   <= {f_w[6:0], 1'b0};
    f3   <= f_w + {f_w[6:0], 1'b0};
    f4   <= {f_w[5:0], 2'b00};
    sy   <= dgr_pkg::div6(11'({glyph_height, 2'b00}) + 11'(glyph_height) + 11'd5);
    sz   <= dgr_pkg::div6(11'(glyph_height) + 11'd5);
  end

  // The pen moves on as soon as a character is taken; the character keeps
  // its own copy of where it starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= '0;
      char_index <= '0;
    end else if (ctl.accept) begin
      pen_x      <= pen_base + dgr_pkg::pen_t'(glyph_width[7:1]);
      char_index <= (idx_base < BOUND) ? idx_base + 1'b1 : BOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_pen <= pen_base;
      prod     <= dgr_pkg::prod_t'(glyph_width) * dgr_pkg::prod_t'(idx_base);
    end
    if (ctl.prep) begin
      gx <= item_pen + dgr_pkg::pen_t'(prod);
      rx <= item_pen + dgr_pkg::pen_t'(prod) + dgr_pkg::pen_t'(w3x2);
    end
  end

  always_comb begin
    unique case (ctl.ysel)
      dgr_pkg::Y_ZERO: yoff = 8'd0;
      dgr_pkg::Y_T:    yoff = t;
      dgr_pkg::Y_2T:   yoff = t2;
      dgr_pkg::Y_F:    yoff = f;
      dgr_pkg::Y_2F:   yoff = f2;
      dgr_pkg::Y_3F:   yoff = f3;
      dgr_pkg::Y_4F:   yoff = f4;
      dgr_pkg::Y_SY:   yoff = sy;
      default:         yoff = 8'd0;
    endcase
    unique case (ctl.hsel)
      dgr_pkg::H_T:    hval = t;
      dgr_pkg::H_F:    hval = f;
      dgr_pkg::H_FULL: hval = glyph_height;
      dgr_pkg::H_4F:   hval = f4;
      dgr_pkg::H_SZ:   hval = sz;
      default:         hval = t;
    endcase
    unique case (ctl.wsel)
      dgr_pkg::W_FULL: wval = glyph_width;
      dgr_pkg::W_BAR:  wval = bw;
      dgr_pkg::W_HALF: wval = half;
      dgr_pkg::W_SZ:   wval = sz;
      default:         wval = glyph_width;
    endcase
  end

  assign out_free = !out_valid || rect_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (rect_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_x    <= ctl.x_rx ? rx : gx;
      out_y    <= {1'b0, top_y} + 13'(yoff);
      out_h    <= hval;
      out_w    <= wval;
      out_last <= ctl.last;
    end
  end

  assign rect_out.valid       = out_valid;
  assign rect_out.rect_x      = out_x;
  assign rect_out.rect_y      = out_y;
  assign rect_out.rect_height = out_h;
  assign rect_out.rect_width  = out_w;
  assign rect_out.last        = out_last;

endmodule

FILE: hw/rtl/dgr_checker.sv
module dgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  char_code,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [15:0] out_x
);

  logic in_beat;
  logic draws;

  assign in_beat = in_valid && in_ready;
  assign draws   = ((char_code >= dgr_pkg::CH_0) && (char_code <= dgr_pkg::CH_9)) ||
                   (char_code == dgr_pkg::CH_DOT);

  // A character that draws nothing leaves the input open.
  a_blank_char: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !draws) |=> in_ready)
    else $error("input closed after a character that draws nothing");

  // A drawing character closes the input while its glyph is produced.
  a_draw_char: assert property (@(posedge clk) disable iff (rst)
    (in_beat && draws) |=> !in_ready)
    else $error("input still open after a drawing character");

  // While a rectangle other than the final one waits, the glyph is not done.
  a_busy_mid_glyph: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input open in the middle of a glyph");

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_last)))
    else $error("output beat changed while stalled");

endmodule

bind digit_glyph_rectangle_generator dgr_checker u_dgr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (char_in.valid),
  .in_ready  (char_in.ready),
  .char_code (char_in.char_code),
  .out_valid (rect_out.valid),
  .out_ready (rect_out.ready),
  .out_last  (rect_out.last),
  .out_x     (rect_out.rect_x)
);

FILE: bench/digit_glyph_rectangle_generator_tb.sv
module digit_glyph_rectangle_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS   = 63;
  localparam int IDX_BOUND   = (MAX_CHARS > 63) ? 63 : MAX_CHARS;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE      = 14;

  // Characters that only move the pen, used by the directed part.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_ONES  = 8'hFF;

  typedef struct packed {
    logic [15:0] x;
    logic [12:0] y;
    logic [7:0]  h;
    logic [7:0]  w;
    logic        last;
  } rect_t;

  typedef struct packed {
    logic [7:0] code;
    logic       restart;
  } char_beat_t;

  class glyph_rect_board;
    logic [7:0]  glyph_h;
    logic [7:0]  glyph_w;
    logic [11:0] origin_x;
    logic [11:0] base_y;
    logic [15:0] pen_x;
    logic [5:0]  char_idx;
    rect_t       expected_rects[$];
    int          errors;

    function new();
      glyph_h  = 8'd15;
      glyph_w  = 8'd9;
      origin_x = '0;
      base_y   = '0;
      pen_x    = '0;
      char_idx = '0;
      errors   = 0;
    endfunction

    function void set_reg(logic [dgr_pkg::CFG_IDX_W-1:0] index,
                          logic [dgr_pkg::CFG_DATA_W-1:0] data);
      case (index)
        dgr_pkg::REG_GLYPH_HEIGHT: glyph_h  = data[7:0];
        dgr_pkg::REG_GLYPH_WIDTH:  glyph_w  = data[7:0];
        dgr_pkg::REG_START_X:      origin_x = data[11:0];
        dgr_pkg::REG_TOP_Y:        base_y   = data[11:0];
        default: ;
      endcase
    endfunction

    function void add_rect(int unsigned x, int unsigned y, int unsigned hgt,
                           int unsigned wid);
      rect_t r;
      r.x    = x[15:0];
      r.y    = y[12:0];
      r.h    = hgt[7:0];
      r.w    = wid[7:0];
      r.last = 1'b0;
      expected_rects.push_back(r);
    endfunction

    function void take_char(logic [7:0] code, logic restart);
      int unsigned w, h, y, gx, rx, bw, t, f;
      int          first;
      if (restart) begin
        pen_x    = 16'(origin_x);
        char_idx = '0;
      end
      first = expected_rects.size();
      w  = glyph_w;
      h  = glyph_h;
      y  = base_y;
      gx = (pen_x + w * char_idx) & 32'hFFFF;
      rx = gx + 2 * (w / 3);
      bw = (w + 2) / 3;
      t  = h / 3;
      f  = h / 5;
      case (code)
        dgr_pkg::CH_0: begin
          add_rect(gx, y, t, w);
          add_rect(gx, y + t, t, bw);
          add_rect(rx, y + t, t, bw);
          add_rect(gx, y + 2 * t, t, w);
        end
        dgr_pkg::CH_1: add_rect(gx, y, h, w / 2);
        dgr_pkg::CH_2, dgr_pkg::CH_3, dgr_pkg::CH_5: begin
          add_rect(gx, y, f, w);
          add_rect((code == dgr_pkg::CH_5) ? gx : rx, y + f, f, bw);
          add_rect(gx, y + 2 * f, f, w);
          add_rect((code == dgr_pkg::CH_2) ? gx : rx, y + 3 * f, f, bw);
          add_rect(gx, y + 4 * f, f, w);
        end
        dgr_pkg::CH_4: begin
          add_rect(gx, y, t, bw);
          add_rect(rx, y, t, bw);
          add_rect(gx, y + t, t, w);
          add_rect(rx, y + 2 * t, t, bw);
        end
        dgr_pkg::CH_6, dgr_pkg::CH_8, dgr_pkg::CH_9: begin
          // Six has no upper right bar, nine no lower left one.
          add_rect(gx, y, f, w);
          add_rect(gx, y + f, f, bw);
          if (code != dgr_pkg::CH_6) add_rect(rx, y + f, f, bw);
          add_rect(gx, y + 2 * f, f, w);
          if (code != dgr_pkg::CH_9) add_rect(gx, y + 3 * f, f, bw);
          add_rect(rx, y + 3 * f, f, bw);
          add_rect(gx, y + 4 * f, f, w);
        end
        dgr_pkg::CH_7: begin
          add_rect(gx, y, f, w);
          add_rect(rx, y + f, 4 * f, bw);
        end
        dgr_pkg::CH_DOT: add_rect(gx, y + (5 * h + 5) / 6, (h + 5) / 6, (h + 5) / 6);
        default: ;
      endcase
      if (expected_rects.size() > first)
        expected_rects[expected_rects.size() - 1].last = 1'b1;
      pen_x = pen_x + 16'(w / 2);
      if (char_idx < IDX_BOUND) char_idx++;
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void check_rect(rect_t got);
      rect_t want;
      if (expected_rects.size() == 0) begin
        errors++;
        $display("%0t: unexpected rectangle, expected none, got x=%0d y=%0d h=%0d w=%0d",
                 $time, got.x, got.y, got.h, got.w);
        return;
      end
      want = expected_rects.pop_front();
      compare_field("rect_x", want.x, got.x);
      compare_field("rect_y", 16'(want.y), 16'(got.y));
      compare_field("rect_height", 16'(want.h), 16'(got.h));
      compare_field("rect_width", 16'(want.w), 16'(got.w));
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           wr_en;
  logic [dgr_pkg::CFG_IDX_W-1:0]  wr_index;
  logic [dgr_pkg::CFG_DATA_W-1:0] wr_data;

  dgr_char_if char_ch ();
  dgr_rect_if rect_ch ();

  glyph_rect_board board;
  char_beat_t      char_plan[$];
  bit              burst_free;
  bit              sink_calm;
  int              idle_cycles;

  digit_glyph_rectangle_generator #(
    .MAX_CHARS(MAX_CHARS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .char_in  (char_ch),
    .rect_out (rect_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Beats on both channels are observed here, and the watchdog runs on them.
  always @(posedge clk) begin
    rect_t seen;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rect_ch.valid && rect_ch.ready) begin
        seen.x    = rect_ch.rect_x;
        seen.y    = rect_ch.rect_y;
        seen.h    = rect_ch.rect_height;
        seen.w    = rect_ch.rect_width;
        seen.last = rect_ch.last;
        board.check_rect(seen);
      end
      if (char_ch.valid && char_ch.ready)
        board.take_char(char_ch.char_code, char_ch.restart);
      if ((rect_ch.valid && rect_ch.ready) || (char_ch.valid && char_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Output back-pressure: runs of ready of random length broken by short stalls.
  initial begin : sink_pacer
    int hold;
    rect_ch.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (sink_calm) begin
        rect_ch.ready <= 1'b1;
      end else if (hold == 0) begin
        if ($urandom_range(0, 2) != 0) begin
          rect_ch.ready <= 1'b1;
          hold = $urandom_range(0, 24);
        end else begin
          rect_ch.ready <= 1'b0;
          hold = $urandom_range(0, 5);
        end
      end else begin
        hold--;
      end
    end
  end

  function automatic logic [7:0] glyph_code(int n);
    case (n)
      0:       return dgr_pkg::CH_0;
      1:       return dgr_pkg::CH_1;
      2:       return dgr_pkg::CH_2;
      3:       return dgr_pkg::CH_3;
      4:       return dgr_pkg::CH_4;
      5:       return dgr_pkg::CH_5;
      6:       return dgr_pkg::CH_6;
      7:       return dgr_pkg::CH_7;
      8:       return dgr_pkg::CH_8;
      9:       return dgr_pkg::CH_9;
      default: return dgr_pkg::CH_DOT;
    endcase
  endfunction

  function automatic char_beat_t random_beat(int draw_pct, int restart_pct);
    char_beat_t b;
    if ($urandom_range(0, 99) < draw_pct) b.code = glyph_code($urandom_range(0, 10));
    else b.code = 8'($urandom_range(0, 255));
    b.restart = ($urandom_range(0, 99) < restart_pct);
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_char(char_beat_t b);
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= b.code;
    char_ch.restart   <= b.restart;
    @(posedge clk);
    while (!char_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_chars();
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    while (char_plan.size() > 0) begin
      send_char(char_plan.pop_front());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if (burst_free) gap = 0;
        else if ($urandom_range(0, 3) == 0) gap = $urandom_range(8, 20);
        else gap = $urandom_range(0, 4);
        if (gap > 0) begin
          char_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    char_ch.valid <= 1'b0;
  endtask

  task automatic write_one(logic [dgr_pkg::CFG_IDX_W-1:0] index,
                           logic [dgr_pkg::CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= data;
    @(posedge clk);
    board.set_reg(index, data);
    @(negedge clk);
  endtask

  // The upper data bits of the 8-bit registers are filled with noise.
  task automatic write_regs(logic [7:0] h, logic [7:0] w, logic [11:0] sx, logic [11:0] ty);
    write_one(dgr_pkg::REG_GLYPH_HEIGHT, {4'($urandom_range(0, 15)), h});
    write_one(dgr_pkg::REG_GLYPH_WIDTH, {4'($urandom_range(0, 15)), w});
    write_one(dgr_pkg::REG_START_X, sx);
    write_one(dgr_pkg::REG_TOP_Y, ty);
    wr_en <= 1'b0;
  endtask

  task automatic drain(int tail);
    while (board.expected_rects.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  initial begin : stimulus
    char_beat_t b;
    rst               = 1'b1;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.restart   = 1'b0;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    burst_free        = 1'b0;
    sink_calm         = 1'b0;
    board             = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: every glyph, then codes that only
    // move the pen, including the neighbors of the digit range.
    for (int i = 0; i < 11; i++) begin
      b.code    = glyph_code(i);
      b.restart = (i == 0);
      char_plan.push_back(b);
    end
    b.restart = 1'b0;
    b.code = CH_DASH;         char_plan.push_back(b);
    b.code = CH_NUL;          char_plan.push_back(b);
    b.code = CH_ONES;         char_plan.push_back(b);
    b.code = CH_SLASH;        char_plan.push_back(b);
    b.code = CH_COLON;        char_plan.push_back(b);
    b.code = CH_HIGH;         char_plan.push_back(b);
    b.code = dgr_pkg::CH_8;   char_plan.push_back(b);
    b.code = dgr_pkg::CH_8;   b.restart = 1'b1; char_plan.push_back(b);
    b.code = dgr_pkg::CH_DOT; b.restart = 1'b0; char_plan.push_back(b);
    play_chars();
    drain(SETTLE);

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_regs(8'd255, 8'd255, 12'hFFF, 12'hFFF);
        1: write_regs(8'd0, 8'd0, 12'h000, 12'h000);
        2: write_regs(8'd1, 8'd1, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        3: write_regs(8'd2, 8'd2, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        default: write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                            12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
      endcase
      burst_free = ($urandom_range(0, 3) == 0);
      sink_calm  = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 30; i++) char_plan.push_back(random_beat(70, 6));
      play_chars();
      drain(SETTLE);
    end

    // A long string restarted only at its start, at a wide glyph: the index saturates and
    // the glyph edge runs far beyond the start register's range.
    write_regs(8'($urandom_range(1, 255)), 8'($urandom_range(230, 255)),
               12'($urandom_range(3000, 4095)), 12'($urandom_range(0, 4095)));
    burst_free = 1'b0;
    sink_calm  = 1'b0;
    b = random_beat(15, 0);
    b.restart = 1'b1;
    char_plan.push_back(b);
    for (int i = 0; i < 119; i++) char_plan.push_back(random_beat(15, 0));
    play_chars();
    drain(2 * SETTLE);

    if (board.errors == 0 && board.expected_rects.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
